// File: rtl/owhm_pkg.sv
// Shared types, constants and tables of the omni-wheel heading mixer.
// Holds the request and response beat structs, the sequencer encodings and the CORDIC table.
// Depends on nothing.
`default_nettype none

package owhm_pkg;

   // Output lanes are fixed by the response beat
   localparam int LANES = 4;

   // Request types
   localparam logic [1:0] REQ_DRIVE   = 2'd0;
   localparam logic [1:0] REQ_ESCAPE  = 2'd1;
   localparam logic [1:0] REQ_BRAKE   = 2'd2;
   localparam logic [1:0] REQ_RELEASE = 2'd3;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_PROP_GAIN = 3'd0;
   localparam logic [2:0] REG_TIME_GAIN = 3'd1;
   localparam logic [2:0] REG_RATE_GAIN = 3'd2;
   localparam logic [2:0] REG_SMOOTHING = 3'd3;
   localparam logic [2:0] REG_ANGLE_A   = 3'd4;
   localparam logic [2:0] REG_ANGLE_B   = 3'd5;
   localparam logic [2:0] REG_ANGLE_C   = 3'd6;
   localparam logic [2:0] REG_ANGLE_D   = 3'd7;

   // Angle constants in Q30 radians
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [16:0]        QUARTER_PI_Q12 = 17'd3217;
   localparam logic [31:0]        DEG_SCALE      = 32'd234684;
   localparam logic [31:0]        MICRO_SCALE    = 32'd1000000;
   localparam logic [40:0]        SUM_LIMIT      = 41'h100_0000_0000;
   localparam logic signed [44:0] POWER_LIMIT    = 45'sd16711680;
   localparam logic [8:0]         SMOOTH_MAX     = 9'd256;

   // Divider geometry
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 7;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] move_dir;
      logic signed [15:0] heading_now;
      logic signed [15:0] heading_goal;
      logic [7:0]         travel_speed;
      logic [31:0]        elapsed_us;
   } owhm_req_type;

   typedef struct packed {
      logic [8:0] duty_a;
      logic [8:0] duty_b;
      logic [8:0] duty_c;
      logic [8:0] duty_d;
      logic       drive_enable;
   } owhm_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIN_LOAD,
      ST_SIN_RED,
      ST_SIN_FOLD,
      ST_SIN_ROT,
      ST_SHARE_MUL,
      ST_GAIN,
      ST_TERM_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PID_SAT,
      ST_PID_MUL,
      ST_BLEND,
      ST_RESULT
   } owhm_state_type;

   typedef enum logic [1:0] {
      OP_SHARE,
      OP_PROP,
      OP_TIME,
      OP_RATE
   } owhm_op_type;

   // arctan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/owhm_div.sv
// Restoring divider of the heading mixer: one quotient bit per cycle.
// Depends on owhm_pkg for its widths.
`default_nettype none

module owhm_div
   import owhm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W+1:0] trial;

   // Shift in one numerator bit, subtract the divisor when it fits
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[DIV_DEN_W+1]) begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

   // A new division never lands on one in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // Done only follows the last busy step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a division");

   // A running division always has steps left
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with empty count");

endmodule

`default_nettype wire

// File: rtl/omni_wheel_heading_mixer_top.sv
// Top level of the omni-wheel heading mixer: register port, sequencer and shared datapath.
// Depends on owhm_pkg and instantiates owhm_div.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  owhm_req_type (move, headings, speed, time)
//   rsp       out        rsp_valid/rsp_ready  owhm_rsp_type (four duties, enable)
//   csr       in/out     psel/penable/pready  pwrite, paddr[4:0], pwdata, prdata
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Brake and release skip the datapath and go straight to the result. Escape, and drive on a
// heading error below pi/4, run one CORDIC of SINE_ITERATIONS steps per wheel and one division
// per wheel share (none when every sine is zero); every drive beat also runs two divisions for
// the timed terms. The serial divider takes up most of the time of a request.
// A finished result waits in the output register; the next request is taken meanwhile.
// Synchronous reset loads the register defaults and clears the stored wheel powers.
`default_nettype none

module omni_wheel_heading_mixer_top
   import owhm_pkg::*;
#(
   parameter int WHEEL_COUNT     = 4,
   parameter int SINE_ITERATIONS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire owhm_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output owhm_rsp_type      rsp_data,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int IterW  = $clog2(SINE_ITERATIONS);
   localparam int WheelW = $clog2(WHEEL_COUNT);
   localparam logic [IterW-1:0]  ITER_LAST  = IterW'(SINE_ITERATIONS - 1);
   localparam logic [WheelW-1:0] WHEEL_LAST = WheelW'(WHEEL_COUNT - 1);

   // Configuration registers
   logic signed [15:0] prop_gain_ff, time_gain_ff, rate_gain_ff;
   logic [8:0]         smoothing_ff;
   logic signed [15:0] angle_ff [LANES];
   logic               cfg_wr;
   logic [2:0]         cfg_idx;

   // Sequencer and datapath
   owhm_state_type     state_ff, state_in;
   owhm_op_type        op_ff, op_in;
   owhm_req_type       req_ff, req_in;
   logic [31:0]        dt_ff, dt_in;
   logic signed [16:0] e_ff, e_in;
   logic [WheelW-1:0]  wheel_ff, wheel_in;
   logic [IterW-1:0]   it_ff, it_in;
   logic signed [35:0] z_ff, z_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] ysave_ff [WHEEL_COUNT];
   logic signed [33:0] ysave_in [WHEEL_COUNT];
   logic [31:0]        mx_ff, mx_in;
   logic signed [24:0] share_ff [LANES];
   logic signed [24:0] share_in [LANES];
   logic [31:0]        gprod_ff, gprod_in;
   logic [63:0]        num_ff, num_in;
   logic [31:0]        den_ff, den_in;
   logic signed [55:0] acc_ff, acc_in;
   logic [40:0]        sat_ff, sat_in;
   logic               neg_ff, neg_in;
   logic signed [44:0] pid_ff, pid_in;
   logic signed [8:0]  prev_ff [LANES];
   logic signed [8:0]  prev_in [LANES];
   owhm_rsp_type       res_ff, res_in;
   logic               rsp_valid_ff;
   owhm_rsp_type       rsp_data_ff;
   logic               rsp_load;

   // Shared units
   logic [40:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        mul_p;
   logic               div_start;
   logic               div_done;
   logic [63:0]        div_quot;

   // Helpers
   logic signed [33:0] cx_next, cy_next;
   logic signed [35:0] cz_next;
   logic signed [33:0] ysel;
   logic [31:0]        ymag;
   logic [31:0]        ynew_mag;
   logic signed [15:0] gsel;
   logic [16:0]        gmag;
   logic [16:0]        emag;
   logic               term_neg;
   logic signed [55:0] add_mag;
   logic               add_neg;
   logic signed [55:0] acc_sum;
   logic signed [8:0]  lane_pow [LANES];
   logic signed [16:0] e_new;
   logic [16:0]        e_new_mag;

   assign pready = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= 16'sd256;
         time_gain_ff <= '0;
         rate_gain_ff <= '0;
         smoothing_ff <= 9'd128;
         angle_ff[0]  <= 16'sd3217;
         angle_ff[1]  <= 16'sd9651;
         angle_ff[2]  <= 16'sd16085;
         angle_ff[3]  <= 16'sd22519;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_PROP_GAIN: prop_gain_ff <= pwdata[15:0];
            REG_TIME_GAIN: time_gain_ff <= pwdata[15:0];
            REG_RATE_GAIN: rate_gain_ff <= pwdata[15:0];
            REG_SMOOTHING: smoothing_ff <= (pwdata[8:0] > SMOOTH_MAX) ? SMOOTH_MAX
                                                                      : pwdata[8:0];
            REG_ANGLE_A:   angle_ff[0] <= pwdata[15:0];
            REG_ANGLE_B:   angle_ff[1] <= pwdata[15:0];
            REG_ANGLE_C:   angle_ff[2] <= pwdata[15:0];
            REG_ANGLE_D:   angle_ff[3] <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads; unaligned addresses read zero
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (cfg_idx)
            REG_PROP_GAIN: prdata = 32'(prop_gain_ff);
            REG_TIME_GAIN: prdata = 32'(time_gain_ff);
            REG_RATE_GAIN: prdata = 32'(rate_gain_ff);
            REG_SMOOTHING: prdata = {23'b0, smoothing_ff};
            REG_ANGLE_A:   prdata = 32'(angle_ff[0]);
            REG_ANGLE_B:   prdata = 32'(angle_ff[1]);
            REG_ANGLE_C:   prdata = 32'(angle_ff[2]);
            REG_ANGLE_D:   prdata = 32'(angle_ff[3]);
            default:       prdata = '0;
         endcase
      end
   end

   // One CORDIC rotation step, floor shifts
   always_comb begin
      logic signed [33:0] dx, dy;
      logic signed [35:0] at;
      dx = y_ff >>> it_ff;
      dy = x_ff >>> it_ff;
      at = $signed({6'b0, atan_q30(5'(it_ff))});
      if (z_ff >= 0) begin
         cx_next = x_ff - dx;
         cy_next = y_ff + dy;
         cz_next = z_ff - at;
      end else begin
         cx_next = x_ff + dx;
         cy_next = y_ff - dy;
         cz_next = z_ff + at;
      end
      ynew_mag = cy_next[33] ? 32'(-cy_next) : 32'(cy_next);
   end

   // Operand picks and magnitudes
   always_comb begin
      logic signed [16:0] gw;
      ysel = ysave_ff[wheel_ff];
      ymag = ysel[33] ? 32'(-ysel) : 32'(ysel);
      case (op_ff)
         OP_TIME: gsel = time_gain_ff;
         OP_RATE: gsel = rate_gain_ff;
         default: gsel = prop_gain_ff;
      endcase
      gw       = 17'(gsel);
      gmag     = gw[16] ? 17'(-gw) : 17'(gw);
      emag     = e_ff[16] ? 17'(-e_ff) : 17'(e_ff);
      term_neg = e_ff[16] ^ gsel[15];
      e_new    = $signed({req_data.heading_goal[15], req_data.heading_goal})
               - $signed({req_data.heading_now[15], req_data.heading_now});
      e_new_mag = e_new[16] ? 17'(-e_new) : 17'(e_new);
   end

   // Shared multiplier
   always_comb begin
      case (state_ff)
         ST_SHARE_MUL: begin
            mul_a = 41'(ymag);
            mul_b = 32'(req_ff.travel_speed);
         end
         ST_GAIN: begin
            mul_a = 41'(emag[15:0]);
            mul_b = 32'(gmag);
         end
         ST_TERM_MUL: begin
            mul_a = 41'(gprod_ff);
            mul_b = (op_ff == OP_TIME) ? dt_ff : MICRO_SCALE;
         end
         ST_PID_MUL: begin
            mul_a = sat_ff;
            mul_b = DEG_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // Signed accumulate of the correction terms
   always_comb begin
      if (state_ff == ST_GAIN) begin
         add_mag = $signed({24'b0, mul_p[31:0]});
      end else begin
         add_mag = $signed({1'b0, div_quot[54:0]});
      end
      add_neg = term_neg;
      acc_sum = add_neg ? acc_ff - add_mag : acc_ff + add_mag;
   end

   // Per wheel: clamp, truncate, blend (escape takes the truncated share instead); unused wheels stay at zero power
   always_comb begin
      logic signed [44:0] t, tc;
      logic [44:0]        tmag;
      logic signed [8:0]  pw, dpow, epow;
      logic [8:0]         inv;
      logic signed [19:0] b;
      logic [19:0]        bmag;
      logic [24:0]        smag;
      for (int w = 0; w < LANES; w++) begin
         t = 45'(share_ff[w]) + pid_ff;
         if (t > POWER_LIMIT) begin
            tc = POWER_LIMIT;
         end else if (t < -POWER_LIMIT) begin
            tc = -POWER_LIMIT;
         end else begin
            tc = t;
         end
         tmag = tc[44] ? 45'(-tc) : 45'(tc);
         pw   = tc[44] ? -$signed({1'b0, tmag[23:16]}) : $signed({1'b0, tmag[23:16]});
         inv  = SMOOTH_MAX - smoothing_ff;
         b    = 20'(prev_ff[w]) * $signed({11'b0, smoothing_ff})
              + 20'(pw) * $signed({11'b0, inv});
         bmag = b[19] ? 20'(-b) : 20'(b);
         dpow = b[19] ? -$signed({1'b0, bmag[15:8]}) : $signed({1'b0, bmag[15:8]});
         smag = share_ff[w][24] ? 25'(-share_ff[w]) : 25'(share_ff[w]);
         epow = share_ff[w][24] ? -$signed({1'b0, smag[23:16]})
                                : $signed({1'b0, smag[23:16]});
         if (w >= WHEEL_COUNT) begin
            lane_pow[w] = '0;
         end else if (req_ff.req_type == REQ_ESCAPE) begin
            lane_pow[w] = epow;
         end else begin
            lane_pow[w] = dpow;
         end
      end
   end

   // Sequencer: next state and datapath loads
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      dt_in     = dt_ff;
      e_in      = e_ff;
      wheel_in  = wheel_ff;
      it_in     = it_ff;
      z_in      = z_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      ysave_in  = ysave_ff;
      mx_in     = mx_ff;
      share_in  = share_ff;
      gprod_in  = gprod_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      neg_in    = neg_ff;
      pid_in    = pid_ff;
      prev_in   = prev_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               dt_in    = (req_data.elapsed_us == '0) ? 32'd1 : req_data.elapsed_us;
               e_in     = e_new;
               wheel_in = '0;
               mx_in    = '0;
               acc_in   = '0;
               op_in    = OP_PROP;
               for (int w = 0; w < LANES; w++) begin
                  share_in[w] = '0;
               end
               if (req_data.req_type inside {REQ_BRAKE, REQ_RELEASE}) begin
                  res_in   = '0;
                  state_in = ST_RESULT;
               end else if (req_data.req_type == REQ_ESCAPE ||
                            e_new_mag < QUARTER_PI_Q12) begin
                  state_in = ST_SIN_LOAD;
               end else begin
                  state_in = ST_GAIN;
               end
            end
         end

         // Angle difference widened to Q30
         ST_SIN_LOAD: begin
            logic signed [16:0] d;
            d = $signed({req_ff.move_dir[15], req_ff.move_dir})
              - $signed({angle_ff[wheel_ff][15], angle_ff[wheel_ff]});
            z_in     = {d[16], d, 18'b0};
            state_in = ST_SIN_RED;
         end

         // Drop whole turns, then fold into [-pi, pi]
         ST_SIN_RED: begin
            if (z_ff >= TWO_PI_Q30) begin
               z_in = z_ff - TWO_PI_Q30;
            end else if (z_ff <= -TWO_PI_Q30) begin
               z_in = z_ff + TWO_PI_Q30;
            end else begin
               if (z_ff > PI_Q30) begin
                  z_in = z_ff - TWO_PI_Q30;
               end else if (z_ff < -PI_Q30) begin
                  z_in = z_ff + TWO_PI_Q30;
               end
               state_in = ST_SIN_FOLD;
            end
         end

         // Mirror into [-pi/2, pi/2] and seed the rotation
         ST_SIN_FOLD: begin
            if (z_ff > HALF_PI_Q30) begin
               z_in = PI_Q30 - z_ff;
            end else if (z_ff < -HALF_PI_Q30) begin
               z_in = -PI_Q30 - z_ff;
            end
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            it_in    = '0;
            state_in = ST_SIN_ROT;
         end

         ST_SIN_ROT: begin
            x_in = cx_next;
            y_in = cy_next;
            z_in = cz_next;
            it_in = it_ff + IterW'(1);
            if (it_ff == ITER_LAST) begin
               ysave_in[wheel_ff] = cy_next;
               if (ynew_mag > mx_ff) begin
                  mx_in = ynew_mag;
               end
               if (wheel_ff == WHEEL_LAST) begin
                  wheel_in = '0;
                  state_in = ST_SHARE_MUL;
               end else begin
                  wheel_in = wheel_ff + WheelW'(1);
                  state_in = ST_SIN_LOAD;
               end
            end
         end

         // Scale each sine so the largest equals the speed
         ST_SHARE_MUL: begin
            op_in  = OP_SHARE;
            num_in = {mul_p[47:0], 16'b0};
            den_in = mx_ff;
            if (mx_ff == '0) begin
               share_in[wheel_ff] = '0;
               if (wheel_ff == WHEEL_LAST) begin
                  wheel_in = '0;
                  op_in    = OP_PROP;
                  state_in = (req_ff.req_type == REQ_ESCAPE) ? ST_BLEND : ST_GAIN;
               end else begin
                  wheel_in = wheel_ff + WheelW'(1);
               end
            end else begin
               state_in = ST_DIV_START;
            end
         end

         // |error| times |gain|; the proportional term goes straight to the sum
         ST_GAIN: begin
            gprod_in = mul_p[31:0];
            if (op_ff == OP_PROP) begin
               acc_in = acc_sum;
               op_in  = OP_TIME;
            end else begin
               state_in = ST_TERM_MUL;
            end
         end

         ST_TERM_MUL: begin
            num_in   = mul_p;
            den_in   = (op_ff == OP_TIME) ? MICRO_SCALE : dt_ff;
            state_in = ST_DIV_START;
         end

         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (div_done) begin
               case (op_ff)
                  OP_SHARE: begin
                     share_in[wheel_ff] = ysel[33] ? -$signed({1'b0, div_quot[23:0]})
                                                   : $signed({1'b0, div_quot[23:0]});
                     if (wheel_ff == WHEEL_LAST) begin
                        wheel_in = '0;
                        op_in    = OP_PROP;
                        state_in = (req_ff.req_type == REQ_ESCAPE) ? ST_BLEND : ST_GAIN;
                     end else begin
                        wheel_in = wheel_ff + WheelW'(1);
                        state_in = ST_SHARE_MUL;
                     end
                  end
                  OP_TIME: begin
                     acc_in   = acc_sum;
                     op_in    = OP_RATE;
                     state_in = ST_GAIN;
                  end
                  default: begin
                     acc_in   = acc_sum;
                     state_in = ST_PID_SAT;
                  end
               endcase
            end
         end

         // Saturate the sum magnitude
         ST_PID_SAT: begin
            logic [55:0] amag;
            amag     = acc_ff[55] ? 56'(-acc_ff) : 56'(acc_ff);
            sat_in   = (amag > 56'(SUM_LIMIT)) ? SUM_LIMIT : amag[40:0];
            neg_in   = acc_ff[55];
            state_in = ST_PID_MUL;
         end

         // Convert to Q16 degrees
         ST_PID_MUL: begin
            pid_in   = neg_ff ? -$signed({3'b0, mul_p[57:16]})
                              : $signed({3'b0, mul_p[57:16]});
            state_in = ST_BLEND;
         end

         // Form duties; 256 + power flips bit 8
         ST_BLEND: begin
            if (req_ff.req_type == REQ_DRIVE) begin
               prev_in = lane_pow;
            end
            res_in.duty_a       = {~lane_pow[0][8], lane_pow[0][7:0]};
            res_in.duty_b       = {~lane_pow[1][8], lane_pow[1][7:0]};
            res_in.duty_c       = {~lane_pow[2][8], lane_pow[2][7:0]};
            res_in.duty_d       = {~lane_pow[3][8], lane_pow[3][7:0]};
            res_in.drive_enable = 1'b1;
            state_in            = ST_RESULT;
         end

         // Hand off to the output register once it is free
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Stored wheel powers and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < LANES; w++) begin
            prev_ff[w] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      req_ff   <= req_in;
      dt_ff    <= dt_in;
      e_ff     <= e_in;
      wheel_ff <= wheel_in;
      it_ff    <= it_in;
      z_ff     <= z_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      ysave_ff <= ysave_in;
      mx_ff    <= mx_in;
      share_ff <= share_in;
      gprod_ff <= gprod_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      acc_ff   <= acc_in;
      sat_ff   <= sat_in;
      neg_ff   <= neg_in;
      pid_ff   <= pid_in;
      res_ff   <= res_in;
   end

   owhm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Divider results arrive only while the sequencer waits for them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("division finished outside the wait state");

   // Blend weight never exceeds one
   a_smooth_range: assert property (@(posedge clock) disable iff (reset)
      smoothing_ff <= SMOOTH_MAX)
      else $error("smoothing above full scale");

   // A finished result holds the sequencer while the output is blocked
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_RESULT)
      else $error("result dropped while output stalled");

   // Brake and release beats skip all arithmetic
   a_brake_direct: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.req_type[1] |=> state_ff == ST_RESULT)
      else $error("brake beat entered the datapath");

endmodule

`default_nettype wire

// File: dv/omni_wheel_heading_mixer_checker.sv
// Checker for the omni-wheel heading mixer: tracks register writes, predicts duties per beat.
// Compares each response beat with the oldest predicted one and counts mismatches.
// Depends on owhm_pkg.
`timescale 1ns / 1ps

module omni_wheel_heading_mixer_checker
   import owhm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  owhm_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  owhm_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic         pready,
   output int           mismatch_count,
   output int           duties_pending
);

   localparam longint PI_Q30_L      = 64'sd3373259426;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint GAIN_Q30_L    = 64'sd652032874;
   localparam longint POWER_MAX     = 255 * 65536;
   localparam int     SINE_STEPS    = 16;

   localparam longint ARCTAN [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   // Shadow of the register file and the stored wheel powers
   int          kp, ki, kd, blend_weight;
   int          mount_angle [4];
   longint      stored_power [4];
   owhm_rsp_type duty_queue [$];

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   // CORDIC sine of a Q4.12 angle, result Q30
   function automatic longint cordic_sine(int angle_q12);
      longint z, x, y, dx, dy;
      z = longint'(angle_q12) * 262144;
      x = GAIN_Q30_L;
      y = 0;
      z = z % (2 * PI_Q30_L);
      if (z > PI_Q30_L) z -= 2 * PI_Q30_L;
      if (z < -PI_Q30_L) z += 2 * PI_Q30_L;
      if (z > HALF_PI_Q30_L) z = PI_Q30_L - z;
      if (z < -HALF_PI_Q30_L) z = -PI_Q30_L - z;
      for (int i = 0; i < SINE_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      return y;
   endfunction

   function automatic longint scaled_term(longint e, int g, longint unsigned num,
                                          longint unsigned den);
      longint unsigned m;
      m = magnitude(e) * magnitude(g) * num / den;
      return ((e < 0) != (g < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint trunc16(longint v);
      longint m;
      m = longint'(magnitude(v) >> 16);
      return v < 0 ? -m : m;
   endfunction

   // Work out the duties of one request beat; drive beats also update the stored powers
   function automatic owhm_rsp_type predict_duties(owhm_req_type r);
      owhm_rsp_type    d;
      longint          sines [4], share [4], power [4];
      longint unsigned peak, m, dt, sm;
      longint          e, sum, pid, t, b;
      logic [8:0]      duty [4];
      for (int w = 0; w < 4; w++) begin
         share[w] = 0;
         power[w] = 0;
      end
      if (r.req_type == REQ_BRAKE || r.req_type == REQ_RELEASE) return '0;
      dt = (r.elapsed_us == 0) ? 1 : r.elapsed_us;
      e = longint'(r.heading_goal) - longint'(r.heading_now);
      // sine mixing, skipped in drive mode on a large heading error
      if (r.req_type == REQ_ESCAPE || magnitude(e) < 3217) begin
         peak = 0;
         for (int w = 0; w < 4; w++) begin
            sines[w] = cordic_sine(int'(r.move_dir) - mount_angle[w]);
            if (magnitude(sines[w]) > peak) peak = magnitude(sines[w]);
         end
         for (int w = 0; w < 4; w++) begin
            if (peak != 0) begin
               m = magnitude(sines[w]) * r.travel_speed * 65536 / peak;
               share[w] = sines[w] < 0 ? -longint'(m) : longint'(m);
            end
         end
      end
      if (r.req_type == REQ_ESCAPE) begin
         for (int w = 0; w < 4; w++) power[w] = trunc16(share[w]);
      end else begin
         sum = e * kp + scaled_term(e, ki, dt, 1000000) + scaled_term(e, kd, 1000000, dt);
         sm = magnitude(sum);
         if (sm > 64'd1099511627776) sm = 64'd1099511627776;
         pid = longint'((sm * 234684) >> 16);
         if (sum < 0) pid = -pid;
         for (int w = 0; w < 4; w++) begin
            t = share[w] + pid;
            if (t > POWER_MAX) t = POWER_MAX;
            if (t < -POWER_MAX) t = -POWER_MAX;
            b = stored_power[w] * blend_weight + trunc16(t) * (256 - blend_weight);
            b = b / 256;
            stored_power[w] = b;
            power[w] = b;
         end
      end
      for (int w = 0; w < 4; w++) duty[w] = 9'(256 + power[w]);
      d.duty_a = duty[0];
      d.duty_b = duty[1];
      d.duty_c = duty[2];
      d.duty_d = duty[3];
      d.drive_enable = 1'b1;
      return d;
   endfunction

   assign duties_pending = duty_queue.size();

   always @(posedge clock) begin
      owhm_rsp_type want;
      if (reset) begin
         kp <= 256; ki <= 0; kd <= 0; blend_weight <= 128;
         mount_angle <= '{3217, 9651, 16085, 22519};
         for (int w = 0; w < 4; w++) stored_power[w] = 0;
         duty_queue.delete();
         mismatch_count <= 0;
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_PROP_GAIN: kp <= int'($signed(pwdata[15:0]));
               REG_TIME_GAIN: ki <= int'($signed(pwdata[15:0]));
               REG_RATE_GAIN: kd <= int'($signed(pwdata[15:0]));
               REG_SMOOTHING: blend_weight <= (pwdata[8:0] > 256) ? 256 : int'(pwdata[8:0]);
               REG_ANGLE_A:   mount_angle[0] <= int'($signed(pwdata[15:0]));
               REG_ANGLE_B:   mount_angle[1] <= int'($signed(pwdata[15:0]));
               REG_ANGLE_C:   mount_angle[2] <= int'($signed(pwdata[15:0]));
               REG_ANGLE_D:   mount_angle[3] <= int'($signed(pwdata[15:0]));
               default: ;
            endcase
         end
         // compare a response beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (duty_queue.size() == 0) begin
               $display("%0t: response beat with none expected, actual %p", $time, rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = duty_queue.pop_front();
               if (rsp_data.duty_a !== want.duty_a || rsp_data.duty_b !== want.duty_b ||
                   rsp_data.duty_c !== want.duty_c || rsp_data.duty_d !== want.duty_d ||
                   rsp_data.drive_enable !== want.drive_enable) begin
                  $display("%0t: duty mismatch, expected %p actual %p", $time, want, rsp_data);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         // predict on each request beat
         if (req_valid && req_ready) duty_queue.push_back(predict_duties(req_data));
      end
   end

endmodule

// File: dv/testbench.sv
// Top of the heading mixer testbench: clock, reset, request and register stimulus, verdict.
// Depends on owhm_pkg, omni_wheel_heading_mixer_top and omni_wheel_heading_mixer_checker.
`timescale 1ns / 1ps

module testbench;
   import owhm_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;

   logic         clock = 0;
   logic         reset;
   logic         req_valid, req_ready, rsp_valid, rsp_ready;
   owhm_req_type req_data;
   owhm_rsp_type rsp_data;
   logic         psel, penable, pwrite, pready;
   logic [4:0]   paddr;
   logic [31:0]  pwdata, prdata;
   int           mismatch_count, duties_pending;
   int           stall_cycles = 0;
   int           send_idle_pct, recv_idle_pct;

   omni_wheel_heading_mixer_top uut (.*);
   omni_wheel_heading_mixer_checker checker_i (.*);

   always #5 clock = ~clock;

   // random response backpressure
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // hold off until every predicted beat has come back
   task automatic drain();
      @(posedge clock);
      while (duties_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_beat(owhm_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic owhm_req_type random_beat();
      owhm_req_type r;
      int pick;
      r.move_dir = 16'($urandom);
      r.heading_now = 16'($urandom);
      r.travel_speed = 8'($urandom);
      pick = $urandom_range(99);
      r.req_type = (pick < 60) ? REQ_DRIVE : (pick < 85) ? REQ_ESCAPE :
                   (pick < 93) ? REQ_BRAKE : REQ_RELEASE;
      // mostly small heading errors so the sine mixing is reached
      if ($urandom_range(99) < 75)
         r.heading_goal = r.heading_now + 16'($signed($urandom_range(6432)) - 3216);
      else
         r.heading_goal = 16'($urandom);
      case ($urandom_range(3))
         0: r.elapsed_us = 0;
         1: r.elapsed_us = $urandom_range(1, 2000);
         2: r.elapsed_us = $urandom_range(1, 2000000);
         default: r.elapsed_us = $urandom;
      endcase
      return r;
   endfunction

   function automatic owhm_req_type make_beat(logic [1:0] kind, logic signed [15:0] dir,
                                              logic signed [15:0] now, logic signed [15:0] goal,
                                              logic [7:0] speed, logic [31:0] us);
      owhm_req_type r;
      r.req_type = kind; r.move_dir = dir; r.heading_now = now;
      r.heading_goal = goal; r.travel_speed = speed; r.elapsed_us = us;
      return r;
   endfunction

   initial begin
      reset <= 1;
      req_valid <= 0; req_data <= '0;
      psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every request type, zero time, large error, zero speed
      send_beat(make_beat(REQ_DRIVE, 0, 0, 0, 255, 1000));
      send_beat(make_beat(REQ_DRIVE, 16'sh7FFF, 16'sh8000, 16'sh8000, 255, 0));
      send_beat(make_beat(REQ_DRIVE, 16'sh8000, 0, 3216, 200, 32'hFFFF_FFFF));
      send_beat(make_beat(REQ_DRIVE, 1000, 0, 3217, 100, 500));
      send_beat(make_beat(REQ_DRIVE, 1000, 0, -3217, 100, 500));
      send_beat(make_beat(REQ_DRIVE, 12868, 16'sh7FFF, 16'sh8000, 255, 1));
      send_beat(make_beat(REQ_DRIVE, 5000, 100, 200, 0, 0));
      send_beat(make_beat(REQ_ESCAPE, 16'sh7FFF, 0, 0, 255, 0));
      send_beat(make_beat(REQ_ESCAPE, 16'sh8000, 0, 0, 1, 1));
      send_beat(make_beat(REQ_ESCAPE, 3217, 16'sh7FFF, 16'sh8000, 0, 7));
      send_beat(make_beat(REQ_BRAKE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 255, 32'hFFFF_FFFF));
      send_beat(make_beat(REQ_RELEASE, 1, 2, 3, 4, 5));
      send_beat(make_beat(REQ_DRIVE, 0, 0, 0, 255, 1000));

      // random phases, each under its own register setting
      for (int phase = 0; phase < 6; phase++) begin
         req_valid <= 0;
         drain();
         case (phase)
            0: ;
            1: begin
               write_reg(REG_PROP_GAIN, 32'h0000_8000);
               write_reg(REG_TIME_GAIN, 32'h0000_7FFF);
               write_reg(REG_RATE_GAIN, 32'h0000_8000);
               write_reg(REG_SMOOTHING, 32'h0000_0000);
            end
            2: begin
               write_reg(REG_PROP_GAIN, 32'h0000_7FFF);
               write_reg(REG_TIME_GAIN, 32'h0000_8000);
               write_reg(REG_RATE_GAIN, 32'h0000_7FFF);
               write_reg(REG_SMOOTHING, 32'h0000_01FF);
               write_reg(REG_ANGLE_A, 32'h0000_7FFF);
               write_reg(REG_ANGLE_B, 32'h0000_8000);
               write_reg(REG_ANGLE_C, 32'h0000_0000);
               write_reg(REG_ANGLE_D, 32'h0000_FFFF);
            end
            3: begin
               write_reg(REG_SMOOTHING, 32'd256);
               write_reg(REG_ANGLE_A, 32'd0);
               write_reg(REG_ANGLE_B, 32'd0);
               write_reg(REG_ANGLE_C, 32'd0);
               write_reg(REG_ANGLE_D, 32'd0);
            end
            default: begin
               write_reg(REG_PROP_GAIN, $urandom_range(0, 2047));
               write_reg(REG_TIME_GAIN, $urandom);
               write_reg(REG_RATE_GAIN, 32'($signed($urandom_range(64)) - 32));
               write_reg(REG_SMOOTHING, $urandom_range(0, 256));
               write_reg(REG_ANGLE_A, $urandom);
               write_reg(REG_ANGLE_B, $urandom);
               write_reg(REG_ANGLE_C, $urandom);
               write_reg(REG_ANGLE_D, $urandom);
            end
         endcase
         for (int n = 0; n < 215; n++) begin
            // idle mix moves from sender-light to sender-heavy to none
            if (phase < 2) begin
               send_idle_pct = 21; recv_idle_pct = 56;
            end else if (phase < 4) begin
               send_idle_pct = 56; recv_idle_pct = 21;
            end else begin
               send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_beat(random_beat());
         end
      end
      req_valid <= 0;
      drain();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
rtl/owhm_pkg.sv
rtl/owhm_div.sv
rtl/omni_wheel_heading_mixer_top.sv
dv/omni_wheel_heading_mixer_checker.sv
dv/testbench.sv
